FILE: hdl/ratacc_pkg.sv
package ratacc_pkg;

	localparam int unsigned FracW = 28;
	localparam int unsigned ProdW = 56;
	localparam logic [ProdW-1:0] OvfLimit = ProdW'(214748364);

	localparam logic [1:0] ActLoad = 2'd0;
	localparam logic [1:0] ActAdd = 2'd1;
	localparam logic [1:0] ActInvert = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [FracW-1:0] numerator;
		logic [FracW-1:0] denominator;
	} in_item_t;

	typedef struct packed {
		logic [FracW-1:0] result_numerator;
		logic [FracW-1:0] result_denominator;
		logic status;
	} out_item_t;

	// Request and reply between the sequencer and the shared reduce unit.
	typedef struct packed {
		logic start;
		logic [ProdW-1:0] num;
		logic [ProdW-1:0] den;
	} red_req_t;

	typedef struct packed {
		logic done;
		logic ok;
		logic [FracW-1:0] num;
		logic [FracW-1:0] den;
	} red_rsp_t;

endpackage

FILE: hdl/ratacc_divider.sv
module ratacc_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ratacc_pkg::FracW-1:0] dividend,
	input  logic [ratacc_pkg::FracW-1:0] divisor,
	output logic done,
	output logic [ratacc_pkg::FracW-1:0] quotient,
	output logic [ratacc_pkg::FracW-1:0] remainder
);
	import ratacc_pkg::*;

	localparam int unsigned CntW = $clog2(FracW + 1);

	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic [FracW-1:0] quo_q;
	logic [FracW-1:0] rem_q;
	logic [FracW-1:0] dvs_q;
	logic [FracW:0] trial;
	logic [FracW:0] shifted;

	// One restoring step per cycle, most significant bit first.
	assign shifted = {rem_q, quo_q[FracW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(FracW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[FracW]) begin
				rem_q <= trial[FracW-1:0];
				quo_q <= {quo_q[FracW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[FracW-1:0];
				quo_q <= {quo_q[FracW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hdl/ratacc_reduce.sv
module ratacc_reduce (
	input  logic clk,
	input  logic arst_n,
	input  ratacc_pkg::red_req_t req,
	output ratacc_pkg::red_rsp_t rsp
);
	import ratacc_pkg::*;

	typedef enum logic [5:0] {
		R_IDLE = 6'b000001,
		R_GCD  = 6'b000010,
		R_WGCD = 6'b000100,
		R_DIVN = 6'b001000,
		R_DIVD = 6'b010000,
		R_WDIV = 6'b100000
	} rstate_t;

	rstate_t state_q;
	logic [FracW-1:0] a_q, b_q, n_q, d_q;
	logic den_phase_q;
	logic div_start;
	logic [FracW-1:0] div_a, div_b, div_q, div_r;
	logic div_done;

	ratacc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done),
		.quotient(div_q), .remainder(div_r)
	);

	always_comb begin
		div_start = 1'b0;
		div_a = a_q;
		div_b = b_q;
		unique case (state_q)
			R_GCD: div_start = 1'b1;
			R_DIVN: begin
				div_start = 1'b1;
				div_a = n_q;
				div_b = a_q;
			end
			R_DIVD: begin
				div_start = 1'b1;
				div_a = d_q;
				div_b = a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			rsp.done <= 1'b0;
			rsp.ok <= 1'b0;
			rsp.num <= '0;
			rsp.den <= '0;
			den_phase_q <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				R_IDLE: if (req.start) begin
					if (req.num > OvfLimit || req.den > OvfLimit) begin
						rsp.done <= 1'b1;
						rsp.ok <= 1'b0;
					end else begin
						state_q <= (req.den == '0) ? R_DIVN : R_GCD;
						den_phase_q <= 1'b0;
					end
				end
				R_GCD: state_q <= R_WGCD;
				R_WGCD: if (div_done) begin
					if (div_r == '0) state_q <= R_DIVN;
					else state_q <= R_GCD;
				end
				R_DIVN: begin
					if (a_q == '0) begin
						rsp.num <= '0;
						rsp.den <= FracW'(1);
						rsp.done <= 1'b1;
						rsp.ok <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						state_q <= R_WDIV;
					end
				end
				R_DIVD: state_q <= R_WDIV;
				R_WDIV: if (div_done) begin
					if (!den_phase_q) begin
						rsp.num <= div_q;
						den_phase_q <= 1'b1;
						state_q <= R_DIVD;
					end else begin
						rsp.den <= div_q;
						rsp.done <= 1'b1;
						rsp.ok <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: if (req.start) begin
				n_q <= req.num[FracW-1:0];
				d_q <= req.den[FracW-1:0];
				// With a zero denominator the gcd is the numerator itself.
				a_q <= req.num[FracW-1:0];
				b_q <= req.den[FracW-1:0];
			end
			R_WGCD: if (div_done) begin
				a_q <= b_q;
				b_q <= div_r;
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/ratacc_mul.sv
module ratacc_mul (
	input  logic clk,
	input  logic [ratacc_pkg::FracW-1:0] a,
	input  logic [ratacc_pkg::FracW-1:0] b,
	output logic [ratacc_pkg::ProdW-1:0] p
);
	import ratacc_pkg::*;

	// Registered 28 by 28 multiplier, shared by the cross products and the denominator product.
	always_ff @(posedge clk) begin
		p <= ProdW'(a) * ProdW'(b);
	end

endmodule

FILE: hdl/rational_accumulator.sv
// rational_accumulator: a running nonnegative fraction updated by one item at a time.
// Input channel in_valid/in_stall carries an item of action, numerator and
// denominator. Load replaces the fraction, add adds a fraction by cross
// multiplication, invert swaps numerator and denominator; an unused action
// changes nothing. Every new value is reduced to lowest terms with a
// Euclidean gcd built from one shared restoring divider (one quotient bit a
// cycle). Output channel out_valid/out_stall carries the stored fraction and
// a status; status 1 marks overflow, in which case the stored fraction is
// left as it was. An unused action goes straight to the output, and an
// overflow is caught as soon as a reduction starts; otherwise an item takes
// its gcd steps plus the two final divisions, and add takes that twice plus
// the multiplications, since the operand is reduced first. The gcd loop
// length sets the time, with at most about 40 steps. One item is in work
// at a time: the input stalls from acceptance until its result has been
// taken, and opens again in the cycle after that. A stalled result holds
// in the output register and the block waits.
// Reset gives the fraction 0/1 and an empty output.
module rational_accumulator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ratacc_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output ratacc_pkg::out_item_t out_item
);
	import ratacc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_RED1  = 8'b00000010,
		S_WRED1 = 8'b00000100,
		S_MUL1  = 8'b00001000,
		S_MUL2  = 8'b00010000,
		S_MUL3  = 8'b00100000,
		S_WRED2 = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [FracW-1:0] run_n_q, run_d_q;
	logic [FracW-1:0] opn_q, opd_q;
	logic [1:0] act_q;
	logic [ProdW-1:0] cross_q;
	logic [ProdW:0] cross_sum;
	logic [FracW-1:0] mul_a, mul_b;
	logic [ProdW-1:0] mul_p;
	logic req2_pend_q;
	red_req_t req;
	red_rsp_t rsp;

	ratacc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	ratacc_reduce u_red (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign in_stall = (state_q != S_IDLE);

	// The multiplier takes run_n*opd, then opn*run_d, then run_d*opd.
	always_comb begin
		mul_a = run_n_q;
		mul_b = opd_q;
		unique case (state_q)
			S_MUL2: begin
				mul_a = opn_q;
				mul_b = run_d_q;
			end
			S_MUL3: begin
				mul_a = run_d_q;
				mul_b = opd_q;
			end
			default: ;
		endcase
	end

	// The sum of the cross products gets one extra bit; a carry saturates
	// the register so that the limit check in the reduce unit still fails.
	assign cross_sum = {1'b0, cross_q} + {1'b0, mul_p};

	// The denominator product leaves the multiplier register in the cycle after
	// S_MUL3, so the second request is started in the first cycle of S_WRED2.
	always_comb begin
		req.start = 1'b0;
		req.num = ProdW'(opn_q);
		req.den = ProdW'(opd_q);
		if (state_q == S_RED1) begin
			req.start = 1'b1;
		end else if (req2_pend_q) begin
			req.start = 1'b1;
			req.num = cross_q;
			req.den = mul_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req2_pend_q <= 1'b0;
		else req2_pend_q <= (state_q == S_MUL3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_n_q <= '0;
			run_d_q <= FracW'(1);
			out_valid <= 1'b0;
			out_item <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					if (in_item.action == ActLoad || in_item.action == ActAdd ||
					    in_item.action == ActInvert) begin
						state_q <= S_RED1;
					end else begin
						out_item.status <= 1'b0;
						out_item.result_numerator <= run_n_q;
						out_item.result_denominator <= run_d_q;
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_RED1: state_q <= S_WRED1;
				S_WRED1: if (rsp.done) begin
					if (rsp.ok && act_q == ActAdd) begin
						state_q <= S_MUL1;
					end else begin
						if (rsp.ok) begin
							run_n_q <= rsp.num;
							run_d_q <= rsp.den;
						end
						out_item.status <= !rsp.ok;
						out_item.result_numerator <= rsp.ok ? rsp.num : run_n_q;
						out_item.result_denominator <= rsp.ok ? rsp.den : run_d_q;
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_WRED2;
				S_WRED2: if (rsp.done) begin
					if (rsp.ok) begin
						run_n_q <= rsp.num;
						run_d_q <= rsp.den;
					end
					out_item.status <= !rsp.ok;
					out_item.result_numerator <= rsp.ok ? rsp.num : run_n_q;
					out_item.result_denominator <= rsp.ok ? rsp.den : run_d_q;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand and cross product registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				act_q <= in_item.action;
				if (in_item.action == ActInvert) begin
					opn_q <= run_d_q;
					opd_q <= run_n_q;
				end else begin
					opn_q <= in_item.numerator;
					opd_q <= in_item.denominator;
				end
			end
			S_WRED1: if (rsp.done) begin
				opn_q <= rsp.num;
				opd_q <= rsp.den;
			end
			S_MUL2: cross_q <= mul_p;
			S_MUL3: cross_q <= cross_sum[ProdW] ? '1 : cross_sum[ProdW-1:0];
			default: ;
		endcase
	end

endmodule
